>>> hw/rtl/lbs_pkg.sv
package lbs_pkg;

    // Scanner geometry
    localparam int unsigned LED_COUNT = 8;
    localparam int unsigned LED_IDX_W = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;

    typedef logic [LED_IDX_W-1:0] t_led_idx;

    localparam t_led_idx LED_LAST = t_led_idx'(LED_COUNT - 1);

    // Levels and limits
    localparam logic [7:0] HEAD_LEVEL = 8'd100;
    localparam logic [7:0] LIT_LEVEL  = 8'd255;
    localparam logic [7:0] SPEED_MAX  = 8'd254;

    // Reset values
    localparam logic [15:0] RST_UP_CODE   = 16'd63750;
    localparam logic [15:0] RST_DOWN_CODE = 16'd47940;
    localparam logic [7:0]  RST_CEILING   = 8'd250;
    localparam logic [7:0]  RST_FLOOR     = 8'd50;
    localparam logic [3:0]  RST_STEP      = 4'd4;
    localparam logic [7:0]  RST_SPEED     = 8'd200;

    // Input commands
    localparam logic [1:0] CMD_TICK   = 2'd0;
    localparam logic [1:0] CMD_FRAME  = 2'd1;
    localparam logic [1:0] CMD_REPEAT = 2'd2;

    // Config register indexes
    localparam int unsigned CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_UP_CODE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DOWN_CODE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CEILING   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FLOOR     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP      = 3'd4;

    // Result kinds
    localparam logic KIND_LED   = 1'b0;
    localparam logic KIND_SPEED = 1'b1;

    // Job queue between front and back
    localparam int unsigned QUEUE_DEPTH = 2;
    localparam int unsigned QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int unsigned QCNT_W = $clog2(QUEUE_DEPTH + 1);

    typedef logic [QPTR_W-1:0] t_qptr;
    typedef logic [QCNT_W-1:0] t_qcnt;

    typedef struct packed {
        logic       kind;   // KIND_LED: scan step, KIND_SPEED: speed report
        logic [7:0] speed;  // speed at the time the job was issued
    } t_job;

endpackage

>>> hw/rtl/led_bounce_scanner_with_trail.sv
// Bouncing LED scanner with a fading trail.
// Input channel (i_in_valid / o_in_stall): one word per event; i_command 0 is a
// tick, 1 a new remote frame carrying i_ir_code, 2 a remote repeat frame.
// Output channel (o_out_valid / i_out_stall): one word per result. A tick that
// expires the divider yields LED_COUNT LED words in index order, the final
// one flagged by o_last; a remote frame yields one speed word (o_kind = 1).
// Config channel (i_cfg_valid / o_cfg_ready, always ready): index 0 up code,
// 1 down code, 2 speed ceiling, 3 speed floor, 4 speed step; write only idle.
// With an idle block an accepted event is written into the job queue, loaded
// into the back's job register, and its first result word is then registered.
// Throughput: the front takes one event per cycle into a two-entry job queue
// while the queue is not full; the back fetches one job at a time, then
// spends one cycle per result word while the output is not stalled.
// Output stall freezes the output register; the back and then the queue
// back up, and o_in_stall rises when the queue is full.
// Reset (synchronous, active low): speed 200, divider 0, head at LED 0
// moving up, all LEDs dark, last code 0, config registers at defaults.
module led_bounce_scanner_with_trail import lbs_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // event input
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic [1:0]           i_command,
    input  logic [15:0]          i_ir_code,
    // config writes
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [15:0]          i_cfg_data,
    // result output
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic                 o_kind,
    output logic [4:0]           o_led_index,
    output logic [7:0]           o_intensity,
    output logic [7:0]           o_speed_now,
    output logic                 o_last
);

    logic q_full;
    logic q_empty;
    logic push;
    logic pop;
    t_job push_job;
    t_job head_job;

    // Front: divider, speed control, config registers
    lbs_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_command   (i_command),
        .i_ir_code   (i_ir_code),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_q_full    (q_full),
        .o_push      (push),
        .o_job       (push_job)
    );

    // Job queue decoupling front from back
    lbs_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_empty (q_empty),
        .o_job   (head_job)
    );

    // Back: LED trail, head walk, result serializer
    lbs_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_empty   (q_empty),
        .i_job       (head_job),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_kind      (o_kind),
        .o_led_index (o_led_index),
        .o_intensity (o_intensity),
        .o_speed_now (o_speed_now),
        .o_last      (o_last)
    );

endmodule

>>> hw/rtl/lbs_front.sv
module lbs_front import lbs_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic [1:0]           i_command,
    input  logic [15:0]          i_ir_code,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [15:0]          i_cfg_data,
    input  logic                 i_q_full,
    output logic                 o_push,
    output t_job                 o_job
);

    logic [15:0] r_up_code,   n_up_code;
    logic [15:0] r_down_code, n_down_code;
    logic [7:0]  r_ceiling,   n_ceiling;
    logic [7:0]  r_floor,     n_floor;
    logic [3:0]  r_step,      n_step;
    logic [7:0]  r_speed,     n_speed;
    logic [7:0]  r_countdown, n_countdown;
    logic [15:0] r_last_code, n_last_code;

    logic        accept;
    logic [15:0] sel_code;
    logic [8:0]  sum;
    logic [7:0]  raised;
    logic [7:0]  lowered;
    logic [7:0]  applied;
    logic [7:0]  dec;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = i_q_full;
    assign accept      = i_in_valid && !i_q_full;

    // Speed update for a remote code
    always_comb begin
        sel_code = (i_command == CMD_FRAME) ? i_ir_code : r_last_code;
        sum      = {1'b0, r_speed} + {5'b0, r_step};
        raised   = (sum > {1'b0, SPEED_MAX}) ? SPEED_MAX : sum[7:0];
        lowered  = (r_speed >= {4'b0, r_step}) ? (r_speed - {4'b0, r_step}) : 8'd0;
        priority if (sel_code == r_up_code) begin
            applied = (r_speed < r_ceiling) ? raised : r_speed;
        end else if (sel_code == r_down_code) begin
            applied = (r_speed > r_floor) ? lowered : r_speed;
        end else begin
            applied = r_speed;
        end
    end

    always_comb begin
        n_up_code   = r_up_code;
        n_down_code = r_down_code;
        n_ceiling   = r_ceiling;
        n_floor     = r_floor;
        n_step      = r_step;
        n_speed     = r_speed;
        n_countdown = r_countdown;
        n_last_code = r_last_code;
        o_push      = 1'b0;
        o_job.kind  = KIND_LED;
        o_job.speed = r_speed;
        dec         = r_countdown - 8'd1;

        if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_UP_CODE:   n_up_code   = i_cfg_data;
                CFG_DOWN_CODE: n_down_code = i_cfg_data;
                CFG_CEILING:   n_ceiling   = i_cfg_data[7:0];
                CFG_FLOOR:     n_floor     = i_cfg_data[7:0];
                CFG_STEP:      n_step      = i_cfg_data[3:0];
                default: ;
            endcase
        end

        if (accept) begin
            unique case (i_command)
                CMD_TICK: begin
                    if (dec != 8'd0) begin
                        n_countdown = dec;
                    end else begin
                        n_countdown = LIT_LEVEL - r_speed;
                        o_push      = 1'b1;
                    end
                end
                CMD_FRAME, CMD_REPEAT: begin
                    if (i_command == CMD_FRAME) begin
                        n_last_code = i_ir_code;
                    end
                    n_speed     = applied;
                    o_push      = 1'b1;
                    o_job.kind  = KIND_SPEED;
                    o_job.speed = applied;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_up_code   <= RST_UP_CODE;
            r_down_code <= RST_DOWN_CODE;
            r_ceiling   <= RST_CEILING;
            r_floor     <= RST_FLOOR;
            r_step      <= RST_STEP;
            r_speed     <= RST_SPEED;
            r_countdown <= 8'd0;
            r_last_code <= 16'd0;
        end else begin
            r_up_code   <= n_up_code;
            r_down_code <= n_down_code;
            r_ceiling   <= n_ceiling;
            r_floor     <= n_floor;
            r_step      <= n_step;
            r_speed     <= n_speed;
            r_countdown <= n_countdown;
            r_last_code <= n_last_code;
        end
    end

endmodule

>>> hw/rtl/lbs_queue.sv
module lbs_queue import lbs_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    output logic o_full,
    input  logic i_pop,
    output logic o_empty,
    output t_job o_job
);

    t_job  r_mem [QUEUE_DEPTH];
    t_qptr r_wr_ptr, n_wr_ptr;
    t_qptr r_rd_ptr, n_rd_ptr;
    t_qcnt r_count,  n_count;

    logic do_push;
    logic do_pop;

    assign o_full  = (r_count == t_qcnt'(QUEUE_DEPTH));
    assign o_empty = (r_count == t_qcnt'(0));
    assign o_job   = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == t_qptr'(QUEUE_DEPTH - 1)) ? t_qptr'(0) : r_wr_ptr + t_qptr'(1);
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == t_qptr'(QUEUE_DEPTH - 1)) ? t_qptr'(0) : r_rd_ptr + t_qptr'(1);
        end
        unique case ({do_push, do_pop})
            2'b10:   n_count = r_count + t_qcnt'(1);
            2'b01:   n_count = r_count - t_qcnt'(1);
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

endmodule

>>> hw/rtl/lbs_back.sv
module lbs_back import lbs_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_q_empty,
    input  t_job       i_job,
    output logic       o_pop,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic       o_kind,
    output logic [4:0] o_led_index,
    output logic [7:0] o_intensity,
    output logic [7:0] o_speed_now,
    output logic       o_last
);

    logic [7:0] r_led [LED_COUNT];
    t_led_idx   r_head, n_head;
    logic       r_down, n_down;
    logic       r_busy, n_busy;
    t_led_idx   r_idx,  n_idx;
    t_job       r_job;

    logic       r_o_valid;
    logic       r_o_kind;
    t_led_idx   r_o_idx;
    logic [7:0] r_o_int;
    logic [7:0] r_o_speed;
    logic       r_o_last;

    logic       out_free;
    logic       emit;
    logic       emit_last;
    logic [7:0] cur_level;
    logic [7:0] new_level;
    t_led_idx   step_head;

    assign out_free  = !r_o_valid || !i_out_stall;
    assign emit      = r_busy && out_free;
    assign o_pop     = !r_busy && !i_q_empty;
    assign emit_last = (r_job.kind == KIND_SPEED) || (r_idx == LED_LAST);
    assign cur_level = r_led[r_idx];

    // Head slot takes the head level; the old head lights fully; others fade.
    always_comb begin
        if (r_idx == r_head) begin
            new_level = HEAD_LEVEL;
        end else if (cur_level == HEAD_LEVEL) begin
            new_level = LIT_LEVEL;
        end else begin
            new_level = cur_level >> 1;
        end
    end

    // Head walk with bounce at both ends
    always_comb begin
        if (r_down) begin
            step_head = (r_head == t_led_idx'(0)) ? t_led_idx'(0) : r_head - t_led_idx'(1);
        end else begin
            step_head = (r_head == LED_LAST) ? LED_LAST : r_head + t_led_idx'(1);
        end
    end

    always_comb begin
        n_busy = r_busy;
        n_idx  = r_idx;
        n_head = r_head;
        n_down = r_down;
        if (o_pop) begin
            n_busy = 1'b1;
            n_idx  = t_led_idx'(0);
        end else if (emit) begin
            n_idx = r_idx + t_led_idx'(1);
            if (emit_last) begin
                n_busy = 1'b0;
                if (r_job.kind == KIND_LED) begin
                    n_head = step_head;
                    if (step_head == LED_LAST || step_head == t_led_idx'(0)) begin
                        n_down = !r_down;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < LED_COUNT; i++) begin
                r_led[i] <= 8'd0;
            end
            r_head    <= '0;
            r_down    <= 1'b0;
            r_busy    <= 1'b0;
            r_idx     <= '0;
            r_o_valid <= 1'b0;
        end else begin
            if (emit && r_job.kind == KIND_LED) begin
                r_led[r_idx] <= new_level;
            end
            r_head <= n_head;
            r_down <= n_down;
            r_busy <= n_busy;
            r_idx  <= n_idx;
            if (out_free) begin
                r_o_valid <= emit;
            end
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_job <= i_job;
        end
        if (emit) begin
            r_o_kind  <= r_job.kind;
            r_o_speed <= r_job.speed;
            r_o_last  <= emit_last;
            if (r_job.kind == KIND_LED) begin
                r_o_idx <= r_idx;
                r_o_int <= new_level;
            end else begin
                r_o_idx <= '0;
                r_o_int <= 8'd0;
            end
        end
    end

    assign o_out_valid = r_o_valid;
    assign o_kind      = r_o_kind;
    assign o_led_index = 5'(r_o_idx);
    assign o_intensity = r_o_int;
    assign o_speed_now = r_o_speed;
    assign o_last      = r_o_last;

endmodule
